// ===== design/frame_contrast_stretch_assert.svh =====
// assertion macros used by the contrast stretch design file
`ifndef FRAME_CONTRAST_STRETCH_ASSERT_SVH
`define FRAME_CONTRAST_STRETCH_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define FCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/fcs_pkg.sv =====
// ----------------------------------------------------------------------------
// fcs_pkg
// constants for the min/max contrast stretch block
// ----------------------------------------------------------------------------
package fcs_pkg;

  localparam int TILE_PIXELS = 64;
  localparam int ADDR_W      = (TILE_PIXELS > 1) ? $clog2(TILE_PIXELS) : 1;
  localparam int CNT_W       = $clog2(TILE_PIXELS + 1);

  localparam int PIX_W       = 16;
  localparam int DIV_STEPS   = PIX_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  localparam logic signed [PIX_W-1:0] PIX_MAX = 16'sh7fff;
  localparam logic signed [PIX_W-1:0] PIX_MIN = 16'sh8000;

  // configuration register indexes, byte address 4*index
  localparam logic REG_OUT_MIN = 1'b0;
  localparam logic REG_OUT_MAX = 1'b1;

endpackage

// ===== design/frame_contrast_stretch.sv =====
// loading: one pixel per cycle, stall low while the tile is being collected
// emission: memory read, 16x16 multiply, radix-2 divide steps (one per
//   quotient bit), output beat, through the one shared restoring divider
// results follow the beat marked last one at a time, each held until taken
// reset (synchronous, active high) clears the frame state and sets
//   out_min = 0, out_max = 255; the pixel memory is not cleared
// ----------------------------------------------------------------------------
// frame_contrast_stretch
// stores one tile, tracks min/max, then emits each pixel linearly remapped
// ----------------------------------------------------------------------------
`include "frame_contrast_stretch_assert.svh"

module frame_contrast_stretch (
  input  logic                              clk,
  input  logic                              rst,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // pixel input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [fcs_pkg::PIX_W-1:0]  pixel_value,
  input  logic                              last_pixel,
  // scaled output
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [fcs_pkg::PIX_W-1:0]  scaled_pixel,
  output logic                              last_result,
  output logic                              flat_frame,
  output logic                              tile_overflow
);

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  localparam int PW = fcs_pkg::PIX_W;
  localparam int AW = fcs_pkg::ADDR_W;
  localparam int CW = fcs_pkg::CNT_W;

  logic [2:0]                 state;
  logic signed [PW-1:0]       out_min;
  logic signed [PW-1:0]       out_max;

  logic signed [PW-1:0]       pixel_store [fcs_pkg::TILE_PIXELS];
  logic signed [PW-1:0]       mem_q;

  logic signed [PW-1:0]       frame_low;
  logic signed [PW-1:0]       frame_high;
  logic [CW-1:0]              stored_count;
  logic                       dropped_flag;

  logic [CW-1:0]              emit_idx;
  logic [CW-1:0]              emit_total;
  logic                       flat;
  logic                       overflow;
  logic                       span_neg;
  logic [PW-1:0]              span_out_mag;
  logic [PW-1:0]              span_in;

  logic [PW-1:0]              rem;
  logic [PW-1:0]              quot;
  logic [fcs_pkg::STEP_W-1:0] step;

  logic                       in_beat;
  logic                       out_beat;
  logic                       store_ok;
  logic signed [PW-1:0]       frame_low_next;
  logic signed [PW-1:0]       frame_high_next;
  logic [CW-1:0]              stored_count_next;
  logic signed [PW:0]         span_out_wide;
  logic signed [PW:0]         span_in_wide;
  logic signed [PW:0]         pix_diff;
  logic [2*PW-1:0]            product;
  logic [PW:0]                trial;
  logic [PW:0]                trial_sub;
  logic [PW-1:0]              quot_signed;
  logic                       cfg_write;

  // ---------------------------------------------------------------- config
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    if (paddr[2] == fcs_pkg::REG_OUT_MAX) begin
      prdata = {{(32-PW){out_max[PW-1]}}, out_max};
    end else begin
      prdata = {{(32-PW){out_min[PW-1]}}, out_min};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_min <= '0;
      out_max <= 16'sd255;
    end else if (cfg_write) begin
      if (paddr[2] == fcs_pkg::REG_OUT_MIN) begin
        out_min <= pwdata[PW-1:0];
      end else begin
        out_max <= pwdata[PW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- load side
  assign in_stall = (state != ST_LOAD);
  assign in_beat  = in_valid && !in_stall;
  assign store_ok = (stored_count < CW'(fcs_pkg::TILE_PIXELS));

  always_comb begin
    frame_low_next    = frame_low;
    frame_high_next   = frame_high;
    stored_count_next = stored_count;
    if (store_ok) begin
      stored_count_next = stored_count + CW'(1);
      if (pixel_value < frame_low) begin
        frame_low_next = pixel_value;
      end
      if (pixel_value > frame_high) begin
        frame_high_next = pixel_value;
      end
    end
  end

  assign span_out_wide = {out_max[PW-1], out_max} - {out_min[PW-1], out_min};
  assign span_in_wide  = {frame_high_next[PW-1], frame_high_next}
                       - {frame_low_next[PW-1], frame_low_next};

  // pixel memory: one write port, registered read at the emit index
  always_ff @(posedge clk) begin
    if (in_beat && store_ok) begin
      pixel_store[stored_count[AW-1:0]] <= pixel_value;
    end
    mem_q <= pixel_store[emit_idx[AW-1:0]];
  end

  // ---------------------------------------------------------------- datapath
  assign pix_diff  = {mem_q[PW-1], mem_q} - {frame_low[PW-1], frame_low};
  assign product   = span_out_mag * pix_diff[PW-1:0];
  assign trial     = {rem, quot[PW-1]};
  assign trial_sub = trial - {1'b0, span_in};

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      frame_low    <= fcs_pkg::PIX_MAX;
      frame_high   <= fcs_pkg::PIX_MIN;
      stored_count <= '0;
      dropped_flag <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (in_beat) begin
            frame_low    <= frame_low_next;
            frame_high   <= frame_high_next;
            stored_count <= stored_count_next;
            if (!store_ok) begin
              dropped_flag <= 1'b1;
            end
            if (last_pixel) begin
              state        <= ST_READ;
              emit_idx     <= '0;
              emit_total   <= stored_count_next;
              flat         <= (frame_low_next == frame_high_next);
              overflow     <= dropped_flag || !store_ok;
              span_neg     <= span_out_wide[PW];
              span_out_mag <= span_out_wide[PW] ? PW'(-span_out_wide)
                                                : span_out_wide[PW-1:0];
              span_in      <= span_in_wide[PW-1:0];
            end
          end
        end
        ST_READ: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          // high half is below the divisor, so 16 steps give the quotient
          rem   <= product[2*PW-1:PW];
          quot  <= product[PW-1:0];
          step  <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (trial >= {1'b0, span_in}) begin
            rem  <= trial_sub[PW-1:0];
            quot <= {quot[PW-2:0], 1'b1};
          end else begin
            rem  <= trial[PW-1:0];
            quot <= {quot[PW-2:0], 1'b0};
          end
          step <= step + fcs_pkg::STEP_W'(1);
          if (step == fcs_pkg::STEP_W'(fcs_pkg::DIV_STEPS - 1)) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            if (last_result) begin
              state        <= ST_LOAD;
              frame_low    <= fcs_pkg::PIX_MAX;
              frame_high   <= fcs_pkg::PIX_MIN;
              stored_count <= '0;
              dropped_flag <= 1'b0;
            end else begin
              emit_idx <= emit_idx + CW'(1);
              state    <= ST_READ;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- output
  assign out_valid     = (state == ST_OUT);
  assign out_beat      = out_valid && !out_stall;
  assign quot_signed   = span_neg ? (PW'(0) - quot) : quot;
  assign scaled_pixel  = flat ? out_min : (out_min + $signed(quot_signed));
  assign last_result   = (emit_idx == (emit_total - CW'(1)));
  assign flat_frame    = flat;
  assign tile_overflow = overflow;

  // ---------------------------------------------------------------- checks
  `FCS_ASSERT_IMP(a_no_load_while_emit, out_valid, in_stall, "input taken during emission")
  `FCS_ASSERT_IMP(a_count_in_range, 1'b1, stored_count <= CW'(fcs_pkg::TILE_PIXELS), "tile count past capacity")
  `FCS_ASSERT_NXT(a_last_ends_frame, out_beat && last_result, !out_valid && stored_count == '0, "frame not closed after last beat")
  `FCS_ASSERT_IMP(a_flat_gives_min, out_valid && flat_frame, scaled_pixel == out_min, "flat frame not at out_min")

endmodule

// ===== tb/frame_contrast_stretch_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_contrast_stretch_test
// drives tiles of pixels into the contrast stretch block and checks every
// remapped beat against a min/max stretch computed alongside the stimulus
// ----------------------------------------------------------------------------
module frame_contrast_stretch_test;

  localparam int SETTLE_CYCLES = 40;

  typedef logic signed [fcs_pkg::PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t scaled;
    logic last;
    logic flat;
    logic overflow;
  } scaled_beat_t;

  typedef enum int {PIX_FULL, PIX_NARROW, PIX_EXTREME} pix_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  pix_t        pixel_value = '0;
  logic        last_pixel = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  pix_t        scaled_pixel;
  logic        last_result;
  logic        flat_frame;
  logic        tile_overflow;

  // stretch state kept beside the block
  pix_t         tile_pixels[$];
  pix_t         tile_low;
  pix_t         tile_high;
  bit           tile_dropped;
  pix_t         target_min;
  pix_t         target_max;
  scaled_beat_t scaled_queue[$];

  bit           failed = 1'b0;
  bit           src_gaps = 1'b1;
  bit           snk_gaps = 1'b1;
  int           sink_hold = 0;
  scaled_beat_t want;

  frame_contrast_stretch DUT (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .pixel_value   (pixel_value),
    .last_pixel    (last_pixel),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .scaled_pixel  (scaled_pixel),
    .last_result   (last_result),
    .flat_frame    (flat_frame),
    .tile_overflow (tile_overflow)
  );

  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic void clear_tile();
    tile_pixels.delete();
    tile_low     = fcs_pkg::PIX_MAX;
    tile_high    = fcs_pkg::PIX_MIN;
    tile_dropped = 1'b0;
  endfunction

  // take one accepted pixel; on the last one, queue the whole stretched tile
  function automatic void stretch_pixel(input pix_t px, input logic lst);
    longint       span_out;
    longint       span_in;
    longint       val;
    scaled_beat_t beat;
    if (tile_pixels.size() < fcs_pkg::TILE_PIXELS) begin
      tile_pixels.push_back(px);
      if (px < tile_low) tile_low = px;
      if (px > tile_high) tile_high = px;
    end else begin
      tile_dropped = 1'b1;
    end
    if (!lst) return;
    span_out = longint'(target_max) - longint'(target_min);
    span_in  = longint'(tile_high) - longint'(tile_low);
    foreach (tile_pixels[k]) begin
      if (span_in <= 0) begin
        val = longint'(target_min);
      end else begin
        val = span_out * (longint'(tile_pixels[k]) - longint'(tile_low)) / span_in
              + longint'(target_min);
      end
      beat.scaled   = val[fcs_pkg::PIX_W-1:0];
      beat.last     = (k == tile_pixels.size() - 1);
      beat.flat     = (tile_low == tile_high);
      beat.overflow = tile_dropped;
      scaled_queue.push_back(beat);
    end
    clear_tile();
  endfunction

  function automatic pix_t draw_pixel(input pix_mode_t mode, input pix_t base);
    case (mode)
      PIX_NARROW: begin
        return base + pix_t'($urandom_range(0, 3));
      end
      PIX_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return fcs_pkg::PIX_MIN;
          1: return fcs_pkg::PIX_MAX;
          2: return pix_t'(0);
          default: return pix_t'(-1);
        endcase
      end
      default: begin
        return pix_t'($urandom);
      end
    endcase
  endfunction

  // valid stays high into the next beat when no gap is drawn
  task automatic send_pixel(input pix_t px, input logic lst);
    int gap;
    gap = src_gaps ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel_value <= px;
    last_pixel  <= lst;
    do @(posedge clk); while (in_stall);
    stretch_pixel(px, lst);
  endtask

  task automatic send_frame(input int len, input pix_mode_t mode);
    pix_t base;
    base = pix_t'($urandom);
    for (int i = 0; i < len; i++) begin
      send_pixel(draw_pixel(mode, base), i == len - 1);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (scaled_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_target(input logic reg_idx, input pix_t val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {{16{val[fcs_pkg::PIX_W-1]}}, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == fcs_pkg::REG_OUT_MIN) target_min = val;
    else target_max = val;
  endtask

  task automatic set_targets(input pix_t lo, input pix_t hi);
    write_target(fcs_pkg::REG_OUT_MIN, lo);
    write_target(fcs_pkg::REG_OUT_MAX, hi);
  endtask

  task automatic test_default_targets();
    send_pixel(fcs_pkg::PIX_MIN, 1'b0);
    send_pixel(fcs_pkg::PIX_MAX, 1'b0);
    send_pixel(pix_t'(0), 1'b0);
    send_pixel(pix_t'(-1), 1'b0);
    send_pixel(pix_t'(1), 1'b0);
    send_pixel(pix_t'(12345), 1'b1);
    drain_results();
  endtask

  task automatic test_flat_frames();
    send_pixel(pix_t'(-5), 1'b1);
    send_pixel(fcs_pkg::PIX_MAX, 1'b0);
    send_pixel(fcs_pkg::PIX_MAX, 1'b0);
    send_pixel(fcs_pkg::PIX_MAX, 1'b1);
    drain_results();
  endtask

  task automatic test_full_range_targets();
    set_targets(fcs_pkg::PIX_MIN, fcs_pkg::PIX_MAX);
    send_pixel(fcs_pkg::PIX_MAX, 1'b0);
    send_pixel(pix_t'(-300), 1'b0);
    send_pixel(fcs_pkg::PIX_MIN, 1'b0);
    send_pixel(pix_t'(7), 1'b0);
    send_pixel(pix_t'(-32767), 1'b1);
    drain_results();
    // reversed targets: the mapping runs downward
    set_targets(fcs_pkg::PIX_MAX, fcs_pkg::PIX_MIN);
    send_pixel(pix_t'(3), 1'b0);
    send_pixel(pix_t'(100), 1'b0);
    send_pixel(pix_t'(-100), 1'b0);
    send_pixel(pix_t'(4), 1'b1);
    drain_results();
  endtask

  task automatic test_equal_targets();
    set_targets(fcs_pkg::PIX_MIN, fcs_pkg::PIX_MIN);
    send_pixel(pix_t'(20), 1'b0);
    send_pixel(pix_t'(-20), 1'b0);
    send_pixel(pix_t'(0), 1'b1);
    drain_results();
  endtask

  task automatic test_tile_overflow();
    set_targets(pix_t'(-1000), pix_t'(1000));
    send_frame(fcs_pkg::TILE_PIXELS, PIX_FULL);
    send_frame(fcs_pkg::TILE_PIXELS + $urandom_range(1, 6), PIX_FULL);
    drain_results();
  endtask

  task automatic test_random_frames();
    int        sent;
    int        len;
    pix_mode_t mode;
    sent = 0;
    while (sent < 110) begin
      src_gaps = ($urandom_range(0, 2) != 0);
      snk_gaps = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 2) == 0) begin
        drain_results();
        case ($urandom_range(0, 4))
          0: set_targets(fcs_pkg::PIX_MIN, fcs_pkg::PIX_MAX);
          1: set_targets(fcs_pkg::PIX_MAX, fcs_pkg::PIX_MIN);
          2: set_targets(pix_t'(0), pix_t'(255));
          default: set_targets(pix_t'($urandom), pix_t'($urandom));
        endcase
      end
      len  = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 12);
      mode = pix_mode_t'($urandom_range(0, 2));
      send_frame(len, mode);
      sent += len;
    end
    drain_results();
  endtask

  // output side: random stall after each beat, every beat checked in order
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (scaled_queue.size() == 0) begin
          $error("unexpected beat: scaled_pixel %0d", scaled_pixel);
          failed = 1'b1;
        end else begin
          want = scaled_queue.pop_front();
          if (scaled_pixel !== want.scaled) begin
            $error("scaled_pixel: expected %0d, got %0d", want.scaled, scaled_pixel);
            failed = 1'b1;
          end
          if (last_result !== want.last) begin
            $error("last_result: expected %0b, got %0b", want.last, last_result);
            failed = 1'b1;
          end
          if (flat_frame !== want.flat) begin
            $error("flat_frame: expected %0b, got %0b", want.flat, flat_frame);
            failed = 1'b1;
          end
          if (tile_overflow !== want.overflow) begin
            $error("tile_overflow: expected %0b, got %0b", want.overflow, tile_overflow);
            failed = 1'b1;
          end
        end
        sink_hold = snk_gaps ? $urandom_range(0, 9) : 0;
        out_stall <= (sink_hold != 0);
      end else if (sink_hold != 0) begin
        sink_hold--;
        out_stall <= (sink_hold != 0);
      end
    end
  end

  initial begin
    clear_tile();
    target_min = pix_t'(0);
    target_max = pix_t'(255);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_targets();
    test_flat_frames();
    test_full_range_targets();
    test_equal_targets();
    test_tile_overflow();
    test_random_frames();
    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
